### src/b64e_pkg.sv
// Shared types, codes and the alphabet lookup of the Base64 stream encoder.
package b64e_pkg;

  // Input item: one raw message byte and its end-of-message flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Result item: one encoded character and its end-of-message flag
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  // Work handed from front to back: up to four characters for one byte
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            fin;
  } cmd_t;

  // Position of the next byte within its three-byte group
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [7:0] enc_sextet(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = 8'h41 + w;
    end else if (v < 6'd52) begin
      c = 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

### src/b64e_front.sv
// Front end: takes bytes, tracks group phase and leftover bits, builds character commands.
module b64e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  b64e_pkg::in_item_t in_item,
  output b64e_pkg::cmd_t     cmd
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic [7:0] b;

  assign b = in_item.data_byte;

  // Classify the byte by phase and form its characters
  always_comb begin
    cmd       = '0;
    cmd.fin   = in_item.last_byte;
    phase_nxt = b64e_pkg::PH_FIRST;
    carry_nxt = '0;
    unique case (phase_r)
      b64e_pkg::PH_SECOND: begin
        cmd.chars[0] = b64e_pkg::enc_sextet({carry_r[1:0], b[7:4]});
        if (in_item.last_byte) begin
          cmd.chars[1] = b64e_pkg::enc_sextet({b[3:0], 2'b00});
          cmd.chars[2] = b64e_pkg::PAD_CHAR;
          cmd.last_idx = 2'd2;
        end else begin
          cmd.last_idx = 2'd0;
          carry_nxt    = b[3:0];
          phase_nxt    = b64e_pkg::PH_THIRD;
        end
      end
      b64e_pkg::PH_THIRD: begin
        cmd.chars[0] = b64e_pkg::enc_sextet({carry_r, b[7:6]});
        cmd.chars[1] = b64e_pkg::enc_sextet(b[5:0]);
        cmd.last_idx = 2'd1;
      end
      default: begin
        // first byte of a group (the unused phase code behaves alike)
        cmd.chars[0] = b64e_pkg::enc_sextet(b[7:2]);
        if (in_item.last_byte) begin
          cmd.chars[1] = b64e_pkg::enc_sextet({b[1:0], 4'b0000});
          cmd.chars[2] = b64e_pkg::PAD_CHAR;
          cmd.chars[3] = b64e_pkg::PAD_CHAR;
          cmd.last_idx = 2'd3;
        end else begin
          cmd.last_idx = 2'd0;
          carry_nxt    = {2'b00, b[1:0]};
          phase_nxt    = b64e_pkg::PH_SECOND;
        end
      end
    endcase
  end

  // Phase and leftover bits advance on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64e_pkg::PH_FIRST;
      carry_r <= '0;
    end else if (push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

### src/b64e_queue.sv
// Small command queue between front and back ends.
module b64e_queue #(
  parameter int QDEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output b64e_pkg::cmd_t head_cmd
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QDEPTH);

  b64e_pkg::cmd_t entry_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### src/b64e_back.sv
// Back end: emits the characters of each command into an output register, one per cycle unless stalled.
module b64e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  b64e_pkg::cmd_t      head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output b64e_pkg::out_item_t out_item
);

  logic [1:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  b64e_pkg::out_item_t out_item_r;
  logic                load;
  logic                at_end;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Load the next character whenever the output register is free or draining
  assign load    = head_valid && (!out_valid_r || out_ready);
  assign at_end  = (idx_r == head_cmd.last_idx);
  assign pop     = load && at_end;
  assign idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        idx_r <= idx_nxt;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r.out_char <= head_cmd.chars[idx_r];
      out_item_r.out_last <= head_cmd.fin && at_end;
    end
  end

endmodule

### src/base64_stream_encoder_top.sv
// Top level of the streaming Base64 encoder (standard alphabet, '=' padding).
//
//   channel | direction | payload              | handshake
//   in_     | input     | in_item_t  (byte)    | in_valid / in_ready
//   out_    | output    | out_item_t (char)    | out_valid / out_ready
//
// Each byte yields one to four characters (4 per 3 bytes in a running message, up to 4
// on the last byte); the back end emits one character per cycle while out_ready does
// not hold the output register.
// An accepted byte passes through a queue entry and then the output register.
// Synchronous active-low reset clears phase, queue and output valid.
// The queue holds QDEPTH commands, so while out_ready is low the input takes about
// QDEPTH more bytes and then stalls until a command drains.
module base64_stream_encoder_top #(
  parameter int QDEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64e_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output b64e_pkg::out_item_t out_item
);

  logic           push, pop, full, head_valid;
  b64e_pkg::cmd_t cmd, head_cmd;

  assign in_ready = !full;
  assign push     = in_valid && in_ready;

  // Byte classification and character forming
  b64e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .cmd     (cmd)
  );

  // Decoupling queue
  b64e_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Character serialiser
  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule
